// ===== hw/rtl/dfps_pkg.sv =====
// Package for the depth-first path search core: beat types and fixed widths.
// No dependencies; imported by the core and its memory blocks.
`default_nettype none

package dfps_pkg;

	// field widths fixed by the interface
	localparam int NODE_BITS  = 4;
	localparam int ECOST_BITS = 16;
	localparam int TOTAL_BITS = 20;
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

	// request modes
	localparam logic MODE_EDGE   = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	typedef struct packed {
		logic                  mode;
		logic [NODE_BITS-1:0]  row;
		logic [NODE_BITS-1:0]  column;
		logic                  connected;
		logic [ECOST_BITS-1:0] edge_cost;
		logic [NODE_BITS-1:0]  start_node;
		logic [NODE_BITS-1:0]  goal_node;
	} req_beat_t;

	typedef struct packed {
		logic [NODE_BITS-1:0]  path_node;
		logic                  found;
		logic [TOTAL_BITS-1:0] total_cost;
		logic                  last;
	} rsp_beat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dfps_adj_store.sv =====
// Adjacency matrix store: one {present, cost} entry per node pair, addressed {row, col}.
// Holds a clearing sweep after reset. Uses dfps_pkg.
`default_nettype none

module dfps_adj_store #(
	parameter int NB        = 4,
	parameter int COST_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [2*NB-1:0]      wr_addr,
	input  wire logic                 wr_present,
	input  wire logic [COST_BITS-1:0] wr_cost,
	input  wire logic                 rd_en,
	input  wire logic [2*NB-1:0]      rd_addr,
	output logic                      rd_present,
	output logic [COST_BITS-1:0]      rd_cost,
	output logic                      busy
);
	import dfps_pkg::*;

	localparam int DEPTH = 1 << (2 * NB);

	logic [COST_BITS:0] mem [DEPTH];
	logic [2*NB-1:0]    clr_addr_q;
	logic               clr_q;
	logic               mem_we;
	logic [2*NB-1:0]    mem_waddr;
	logic [COST_BITS:0] mem_wdata;
	logic [COST_BITS:0] rdata_q;

	assign busy = clr_q;

	// clearing sweep, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == (2*NB)'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// write port mux: sweep has priority
	always_comb begin
		mem_we    = clr_q | wr_en;
		mem_waddr = clr_q ? clr_addr_q : wr_addr;
		mem_wdata = clr_q ? '0 : {wr_present, wr_cost};
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign rd_present = rdata_q[COST_BITS];
	assign rd_cost    = rdata_q[COST_BITS-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/dfps_stack.sv =====
// Path stack memory: node index and saturated cost from start, one entry per depth.
// One write and one registered read port. Uses dfps_pkg.
`default_nettype none

module dfps_stack #(
	parameter int NB    = 4,
	parameter int DEPTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            wr_en,
	input  wire logic [NB-1:0]                   wr_addr,
	input  wire logic [NB+dfps_pkg::TOTAL_BITS-1:0] wr_data,
	input  wire logic                            rd_en,
	input  wire logic [NB-1:0]                   rd_addr,
	output logic [NB+dfps_pkg::TOTAL_BITS-1:0]   rd_data
);
	import dfps_pkg::*;

	localparam int W = NB + TOTAL_BITS;

	logic [W-1:0] mem [DEPTH];

	// entries are always written before they are read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/depth_first_path_search_core.sv =====
// Depth-first path search core.
// Request channel (req_valid / req_stall / req): mode 0 beats write one matrix entry
// {connected, edge_cost} at (row, column); entries outside NODES are dropped.
// Mode 1 beats search from start_node to goal_node. Neighbours are tried in rising
// order, visited marks stay set, the walk stops at the goal.
// Response channel (rsp_valid / rsp_stall / rsp): one beat per path node, start first,
// each with found = 1 and the path cost (saturated at 2^20-1), last on the goal.
// A failed search gives one beat: node 0, found 0, cost 0, last 1.
// A search reads one matrix entry at a time over the walk (at most NODES*NODES reads),
// with further steps for each node pushed, each backtrack and each result beat.
// The search speed is set by the single read port of the adjacency memory.
// Only one search is in flight; the next request is taken once the last result is in
// the output register.
// Reset: the adjacency memory is swept to zero, one entry a cycle, over all of its
// entries (256 at the default); req_stall stays high meanwhile.
// A stalled response holds in the output register; the next result beat waits for it.
`default_nettype none

module depth_first_path_search_core #(
	parameter int NODES     = 16,
	parameter int COST_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire dfps_pkg::req_beat_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output dfps_pkg::rsp_beat_t      rsp
);
	import dfps_pkg::*;

	localparam int NB  = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int SW  = ((COST_BITS > TOTAL_BITS) ? COST_BITS : TOTAL_BITS) + 1;
	localparam int CXW = (COST_BITS > ECOST_BITS) ? COST_BITS : ECOST_BITS;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SCAN   = 6'b000010,
		ST_POP    = 6'b000100,
		ST_OUT_RD = 6'b001000,
		ST_OUT_LD = 6'b010000,
		ST_MISS   = 6'b100000
	} state_t;

	state_t                state_q;
	logic [NODES-1:0]      visited_q;
	logic [NB:0]           depth_q;
	logic [NB-1:0]         top_q;
	logic [TOTAL_BITS-1:0] cum_q;
	logic [NB:0]           n_q;
	logic [NB-1:0]         nr_q;
	logic                  pend_q;
	logic [NB-1:0]         idx_q;
	logic [NODE_BITS-1:0]  goal_q;
	logic                  rsp_valid_q;
	rsp_beat_t             rsp_q;

	logic                  adj_busy;
	logic                  adj_wr_en;
	logic [2*NB-1:0]       adj_wr_addr;
	logic [COST_BITS-1:0]  adj_wr_cost;
	logic                  adj_rd_en;
	logic [2*NB-1:0]       adj_rd_addr;
	logic                  adj_rd_present;
	logic [COST_BITS-1:0]  adj_rd_cost;
	logic [CXW-1:0]        edge_cost_x;

	logic                       stk_wr_en;
	logic [NB-1:0]              stk_wr_addr;
	logic [NB+TOTAL_BITS-1:0]   stk_wr_data;
	logic                       stk_rd_en;
	logic [NB-1:0]              stk_rd_addr;
	logic [NB+TOTAL_BITS-1:0]   stk_rd_data;
	logic [NB-1:0]              stk_node;
	logic [TOTAL_BITS-1:0]      stk_cum;

	logic                  req_take;
	logic                  edge_ok;
	logic                  start_ok;
	logic [NB-1:0]         start_idx;
	logic                  hit;
	logic                  more;
	logic                  pop;
	logic [SW-1:0]         sum;
	logic [TOTAL_BITS-1:0] sum_sat;
	logic                  out_free;
	logic                  out_last;
	logic                  rsp_load;

	assign req_stall = (state_q != ST_IDLE) || adj_busy;
	assign req_take  = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_load  = out_free && ((state_q == ST_OUT_LD) || (state_q == ST_MISS));

	assign edge_ok   = (32'(req.row) < NODES) && (32'(req.column) < NODES);
	assign start_ok  = 32'(req.start_node) < NODES;
	assign start_idx = NB'(req.start_node);

	assign edge_cost_x = CXW'(req.edge_cost);

	assign stk_node = stk_rd_data[NB+TOTAL_BITS-1:TOTAL_BITS];
	assign stk_cum  = stk_rd_data[TOTAL_BITS-1:0];

	// scan step: check last read entry, issue next one
	assign hit  = (state_q == ST_SCAN) && pend_q && adj_rd_present && !visited_q[nr_q];
	assign more = n_q < (NB+1)'(NODES);
	assign pop  = (state_q == ST_SCAN) && !hit && !more;

	// saturating path cost to the candidate node
	assign sum     = SW'(cum_q) + SW'(adj_rd_cost);
	assign sum_sat = (sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];

	assign out_last = ((NB+1)'(idx_q) + 1'b1) == depth_q;

	// memory port control
	always_comb begin
		adj_wr_en   = req_take && (req.mode == MODE_EDGE) && edge_ok;
		adj_wr_addr = {NB'(req.row), NB'(req.column)};
		adj_wr_cost = edge_cost_x[COST_BITS-1:0];
		adj_rd_en   = (state_q == ST_SCAN) && !hit && more;
		adj_rd_addr = {top_q, n_q[NB-1:0]};

		stk_wr_en   = 1'b0;
		stk_wr_addr = '0;
		stk_wr_data = {start_idx, {TOTAL_BITS{1'b0}}};
		if (req_take && (req.mode == MODE_SEARCH) && start_ok) begin
			stk_wr_en = 1'b1;
		end else if (hit) begin
			stk_wr_en   = 1'b1;
			stk_wr_addr = depth_q[NB-1:0];
			stk_wr_data = {nr_q, sum_sat};
		end

		stk_rd_en   = 1'b0;
		stk_rd_addr = idx_q;
		if (pop && (depth_q != (NB+1)'(1))) begin
			stk_rd_en   = 1'b1;
			stk_rd_addr = NB'(depth_q - (NB+1)'(2));
		end else if (state_q == ST_OUT_RD) begin
			stk_rd_en = 1'b1;
		end
	end

	// walk sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			visited_q   <= '0;
			depth_q     <= '0;
			top_q       <= '0;
			cum_q       <= '0;
			n_q         <= '0;
			nr_q        <= '0;
			pend_q      <= 1'b0;
			idx_q       <= '0;
			goal_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// taken beat drops valid unless a new one loads this cycle
			if (rsp_valid_q && !rsp_stall && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_take && (req.mode == MODE_SEARCH)) begin
						goal_q <= req.goal_node;
						if (!start_ok) begin
							visited_q <= '0;
							depth_q   <= '0;
							state_q   <= ST_MISS;
						end else begin
							visited_q <= NODES'(1) << start_idx;
							depth_q   <= (NB+1)'(1);
							top_q     <= start_idx;
							cum_q     <= '0;
							n_q       <= '0;
							pend_q    <= 1'b0;
							idx_q     <= '0;
							state_q   <= (req.start_node == req.goal_node) ? ST_OUT_RD : ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (hit) begin
						visited_q[nr_q] <= 1'b1;
						depth_q         <= depth_q + 1'b1;
						top_q           <= nr_q;
						cum_q           <= sum_sat;
						n_q             <= '0;
						pend_q          <= 1'b0;
						if (32'(nr_q) == 32'(goal_q)) begin
							idx_q   <= '0;
							state_q <= ST_OUT_RD;
						end
					end else if (more) begin
						nr_q   <= n_q[NB-1:0];
						n_q    <= n_q + 1'b1;
						pend_q <= 1'b1;
					end else begin
						// backtrack; resume the parent after this node
						pend_q  <= 1'b0;
						depth_q <= depth_q - 1'b1;
						n_q     <= (NB+1)'(top_q) + 1'b1;
						state_q <= (depth_q == (NB+1)'(1)) ? ST_MISS : ST_POP;
					end
				end
				ST_POP: begin
					top_q   <= stk_node;
					cum_q   <= stk_cum;
					state_q <= ST_SCAN;
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_LD;
				end
				ST_OUT_LD: begin
					if (out_free) begin
						rsp_valid_q      <= 1'b1;
						rsp_q.path_node  <= NODE_BITS'(stk_node);
						rsp_q.found      <= 1'b1;
						rsp_q.total_cost <= cum_q;
						rsp_q.last       <= out_last;
						if (out_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_OUT_RD;
						end
					end
				end
				ST_MISS: begin
					depth_q <= '0;
					if (out_free) begin
						rsp_valid_q      <= 1'b1;
						rsp_q.path_node  <= '0;
						rsp_q.found      <= 1'b0;
						rsp_q.total_cost <= '0;
						rsp_q.last       <= 1'b1;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	dfps_adj_store #(
		.NB        (NB),
		.COST_BITS (COST_BITS)
	) u_adj (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (adj_wr_en),
		.wr_addr    (adj_wr_addr),
		.wr_present (req.connected),
		.wr_cost    (adj_wr_cost),
		.rd_en      (adj_rd_en),
		.rd_addr    (adj_rd_addr),
		.rd_present (adj_rd_present),
		.rd_cost    (adj_rd_cost),
		.busy       (adj_busy)
	);

	dfps_stack #(
		.NB    (NB),
		.DEPTH (NODES)
	) u_stack (
		.clk     (clk),
		.wr_en   (stk_wr_en),
		.wr_addr (stk_wr_addr),
		.wr_data (stk_wr_data),
		.rd_en   (stk_rd_en),
		.rd_addr (stk_rd_addr),
		.rd_data (stk_rd_data)
	);

	// the node on top of the stack is always marked visited
	a_top_visited: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> visited_q[top_q])
		else $error("top of stack not visited");

	// stack depth stays within the node count
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= (NB+1)'(NODES))
		else $error("stack depth overflow");

	// a failed search is a single closing beat with zero cost
	a_miss_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.found) |-> (rsp_q.last && (rsp_q.total_cost == '0)))
		else $error("bad not-found beat");

	// no walk reads while the matrix is being cleared
	a_no_read_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adj_busy |-> (!adj_rd_en && (state_q == ST_IDLE)))
		else $error("matrix access during clear");

	// a new result only loads once the previous one was taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |=> (rsp_valid_q && $stable(rsp_q)))
		else $error("stalled result overwritten");

endmodule

`default_nettype wire

// ===== bench/depth_first_path_search_core_tb.sv =====
// Self-checking bench for depth_first_path_search_core: directed table, then random graph phases.
// Depends on dfps_pkg and the core RTL; an in-bench path predictor checks every response beat.
`timescale 1ns / 1ps

module depth_first_path_search_core_tb;
	import dfps_pkg::*;

	localparam int NODE_COUNT   = 16;
	localparam int COST_WIDTH   = 16;
	localparam int ITEM_TARGET  = 220;
	localparam int QUIET_FROM   = 185;
	localparam int DRAIN_CYCLES = 600;
	localparam int LIMIT_CYCLES = 400000;

	typedef struct {
		req_beat_t beat;
		bit        typed;
		rsp_beat_t want;
	} stim_row_t;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_beat_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_beat_t rsp;

	// predictor copy of the adjacency matrix
	logic                  link_on   [NODE_COUNT][NODE_COUNT];
	logic [ECOST_BITS-1:0] link_cost [NODE_COUNT][NODE_COUNT];

	rsp_beat_t path_beats_due [$];
	stim_row_t directed_rows [$];

	int items_sent     = 0;
	int mismatch_count = 0;
	int cycle_count    = 0;
	int idle_odds      = 4;
	int hold_left      = 0;

	depth_first_path_search_core #(
		.NODES    (NODE_COUNT),
		.COST_BITS(COST_WIDTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// timeout
	initial begin
		wait (cycle_count >= LIMIT_CYCLES);
		$display("timeout after %0d cycles, %0d beats still due", cycle_count,
			path_beats_due.size());
		$display("depth_first_path_search_core_tb: FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		mismatch_count++;
		$display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
	endtask

	// append one expected response beat
	task automatic queue_due(input rsp_beat_t r);
		path_beats_due.insert(path_beats_due.size(), r);
	endtask

	// append one row to the directed table
	task automatic add_row(input req_beat_t b, input bit typed, input rsp_beat_t want);
		stim_row_t row;
		row.beat  = b;
		row.typed = typed;
		row.want  = want;
		directed_rows.insert(directed_rows.size(), row);
	endtask

	function automatic logic [ECOST_BITS-1:0] pick_cost();
		int unsigned roll;
		roll = $urandom_range(0, 7);
		if (roll < 2)
			return '1;
		else if (roll == 2)
			return '0;
		return ECOST_BITS'($urandom);
	endfunction

	// edge write; search fields are don't-care and randomized
	function automatic req_beat_t edge_beat(input int unsigned r, input int unsigned c,
		input bit conn, input logic [ECOST_BITS-1:0] cost);
		req_beat_t b;
		b.mode       = MODE_EDGE;
		b.row        = NODE_BITS'(r);
		b.column     = NODE_BITS'(c);
		b.connected  = conn;
		b.edge_cost  = cost;
		b.start_node = NODE_BITS'($urandom);
		b.goal_node  = NODE_BITS'($urandom);
		return b;
	endfunction

	// search; edge fields are don't-care and randomized
	function automatic req_beat_t search_beat(input int unsigned src, input int unsigned dst);
		req_beat_t b;
		b.mode       = MODE_SEARCH;
		b.row        = NODE_BITS'($urandom);
		b.column     = NODE_BITS'($urandom);
		b.connected  = 1'($urandom);
		b.edge_cost  = ECOST_BITS'($urandom);
		b.start_node = NODE_BITS'(src);
		b.goal_node  = NODE_BITS'(dst);
		return b;
	endfunction

	// single-beat response: start==goal or not found
	function automatic rsp_beat_t lone_beat(input int unsigned node, input bit hit);
		rsp_beat_t r;
		r.path_node  = NODE_BITS'(node);
		r.found      = hit;
		r.total_cost = '0;
		r.last       = 1'b1;
		return r;
	endfunction

	// DFS walk over the predictor matrix; queues the expected path beats
	task automatic walk_expected_path(input logic [NODE_BITS-1:0] src,
		input logic [NODE_BITS-1:0] dst);
		logic [NODE_COUNT-1:0] seen;
		logic [NODE_BITS-1:0]  trail  [NODE_COUNT];
		int unsigned           resume [NODE_COUNT];
		int unsigned           depth, lvl, nb, sum, i;
		bit                    hit, pushed;
		rsp_beat_t             r;
		seen      = '0;
		trail[0]  = src;
		resume[0] = 0;
		seen[src] = 1'b1;
		depth     = 1;
		hit       = (src == dst);
		while (!hit && depth > 0) begin
			lvl    = depth - 1;
			pushed = 1'b0;
			for (nb = resume[lvl]; nb < NODE_COUNT; nb++) begin
				if (link_on[trail[lvl]][nb] && !seen[nb]) begin
					resume[lvl] = nb + 1;
					if (depth < NODE_COUNT) begin
						trail[depth]  = NODE_BITS'(nb);
						resume[depth] = 0;
						depth++;
					end
					seen[nb] = 1'b1;
					pushed   = 1'b1;
					break;
				end
			end
			if (pushed) begin
				if (nb == dst)
					hit = 1'b1;
			end else begin
				depth--;
			end
		end
		if (!hit) begin
			queue_due(lone_beat(0, 1'b0));
		end else begin
			sum = 0;
			for (i = 1; i < depth; i++) begin
				sum += link_cost[trail[i-1]][trail[i]];
				if (sum > TOTAL_MAX)
					sum = TOTAL_MAX;
			end
			for (i = 0; i < depth; i++) begin
				r.path_node  = trail[i];
				r.found      = 1'b1;
				r.total_cost = TOTAL_BITS'(sum);
				r.last       = (i + 1 == depth);
				queue_due(r);
			end
		end
	endtask

	// present one request beat, hold it until taken, then update the predictor
	task automatic send_beat(input req_beat_t b, input bit typed, input rsp_beat_t want);
		int gap;
		gap = 0;
		if (items_sent >= QUIET_FROM)
			idle_odds = 0;
		if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
			gap = $urandom_range(1, 4);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= b;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		items_sent++;
		if (b.mode == MODE_EDGE) begin
			link_on[b.row][b.column]   = b.connected;
			link_cost[b.row][b.column] = b.edge_cost;
		end else if (typed) begin
			queue_due(want);
		end else begin
			walk_expected_path(b.start_node, b.goal_node);
		end
	endtask

	// response side: check accepted beats, then pick next cycle's stall
	always @(posedge clk) begin : rsp_side
		rsp_beat_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (path_beats_due.size() == 0) begin
				report_mismatch("beat with nothing due", rsp, 0);
			end else begin
				want = path_beats_due.pop_front();
				if (rsp.path_node != want.path_node)
					report_mismatch("path_node", rsp.path_node, want.path_node);
				if (rsp.found != want.found)
					report_mismatch("found", rsp.found, want.found);
				if (rsp.total_cost != want.total_cost)
					report_mismatch("total_cost", rsp.total_cost, want.total_cost);
				if (rsp.last != want.last)
					report_mismatch("last", rsp.last, want.last);
			end
		end
		if (idle_odds == 0) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
		end else if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if ($urandom_range(0, idle_odds - 1) == 0) begin
			rsp_stall <= 1'b1;
			hold_left <= $urandom_range(0, 3);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// stimulus
	initial begin : stim
		int                    perm [NODE_COUNT];
		int                    i, j, tmp, len, cnt, src, pick;
		logic [63:0]           raw;
		req_beat_t             b;
		for (i = 0; i < NODE_COUNT; i++) begin
			for (j = 0; j < NODE_COUNT; j++) begin
				link_on[i][j]   = 1'b0;
				link_cost[i][j] = '0;
			end
		end

		// directed table: typed rows are single-beat answers readable at a glance
		add_row(search_beat(0, 0), 1'b1, lone_beat(0, 1'b1));
		add_row(search_beat(0, 15), 1'b1, lone_beat(0, 1'b0));
		add_row(search_beat(15, 15), 1'b1, lone_beat(15, 1'b1));
		add_row(edge_beat(0, 1, 1'b1, '1), 1'b0, '0);
		add_row(edge_beat(1, 15, 1'b1, '0), 1'b0, '0);
		add_row(edge_beat(15, 15, 1'b1, '1), 1'b0, '0);
		add_row(edge_beat(0, 0, 1'b1, '0), 1'b0, '0);
		add_row(search_beat(0, 15), 1'b0, '0);
		// node 15 has only a self loop, never followed
		add_row(search_beat(15, 0), 1'b1, lone_beat(0, 1'b0));
		// cost stored while the edge stays absent
		add_row(edge_beat(1, 2, 1'b0, '1), 1'b0, '0);
		add_row(search_beat(1, 2), 1'b1, lone_beat(0, 1'b0));
		add_row(edge_beat(1, 2, 1'b1, 16'h1234), 1'b0, '0);
		add_row(search_beat(0, 2), 1'b0, '0);
		add_row(edge_beat(2, 0, 1'b1, 16'd7), 1'b0, '0);
		add_row(search_beat(2, 15), 1'b0, '0);
		add_row(edge_beat(0, 1, 1'b0, '0), 1'b0, '0);
		add_row(search_beat(0, 15), 1'b1, lone_beat(0, 1'b0));
		// dead end at 4 forces a backtrack before 0 -> 5 -> 15
		add_row(edge_beat(0, 3, 1'b1, 16'd100), 1'b0, '0);
		add_row(edge_beat(3, 4, 1'b1, 16'd200), 1'b0, '0);
		add_row(edge_beat(0, 5, 1'b1, 16'd300), 1'b0, '0);
		add_row(edge_beat(5, 15, 1'b1, '1), 1'b0, '0);
		add_row(search_beat(0, 15), 1'b0, '0);
		add_row(search_beat(5, 5), 1'b1, lone_beat(5, 1'b1));
		add_row(search_beat(4, 0), 1'b1, lone_beat(0, 1'b0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k])
			send_beat(directed_rows[k].beat, directed_rows[k].typed, directed_rows[k].want);

		// random graph phases
		while (items_sent < ITEM_TARGET) begin
			idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				// chain through a shuffled node order, then search its ends
				for (i = 0; i < NODE_COUNT; i++)
					perm[i] = i;
				for (i = NODE_COUNT - 1; i > 0; i--) begin
					j       = $urandom_range(0, i);
					tmp     = perm[i];
					perm[i] = perm[j];
					perm[j] = tmp;
				end
				len = $urandom_range(2, NODE_COUNT);
				for (i = 0; i + 1 < len; i++)
					send_beat(edge_beat(perm[i], perm[i+1], 1'b1, pick_cost()), 1'b0, '0);
				send_beat(search_beat(perm[0], perm[len-1]), 1'b0, '0);
				if ($urandom_range(0, 1) == 0)
					send_beat(search_beat(perm[len-1], perm[0]), 1'b0, '0);
			end else if (pick < 8) begin
				// scattered edge writes and removals, then a few searches
				cnt = $urandom_range(4, 12);
				for (i = 0; i < cnt; i++)
					send_beat(edge_beat($urandom_range(0, NODE_COUNT - 1),
						$urandom_range(0, NODE_COUNT - 1), 1'($urandom), pick_cost()),
						1'b0, '0);
				cnt = $urandom_range(2, 5);
				for (i = 0; i < cnt; i++) begin
					src = $urandom_range(0, NODE_COUNT - 1);
					if ($urandom_range(0, 5) == 0)
						send_beat(search_beat(src, src), 1'b0, '0);
					else
						send_beat(search_beat(src, $urandom_range(0, NODE_COUNT - 1)),
							1'b0, '0);
				end
			end else begin
				// fully random beats
				cnt = $urandom_range(3, 6);
				for (i = 0; i < cnt; i++) begin
					raw = {$urandom, $urandom};
					b   = raw[$bits(req_beat_t)-1:0];
					send_beat(b, 1'b0, '0);
				end
			end
		end
		req_valid <= 1'b0;

		while (path_beats_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("depth_first_path_search_core_tb: PASS");
		else
			$display("depth_first_path_search_core_tb: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/dfps_pkg.sv
hw/rtl/dfps_adj_store.sv
hw/rtl/dfps_stack.sv
hw/rtl/depth_first_path_search_core.sv
bench/depth_first_path_search_core_tb.sv
